### src/mk_pkg.sv
// Shared types, constants and the character code table for the Morse keyer.
// No dependencies; imported by mk_seq and morse_keyer.

package mk_pkg;

    localparam int CHAR_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int DUR_W   = 19;
    localparam int ELEM_W  = 3;   // element index / count
    localparam int MAX_ELEM = 7;

    localparam logic [UNIT_W-1:0] TIME_UNIT_RESET = 16'd50;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A    = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z    = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_OFFSET     = 8'd32;

    // input item kind
    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_EOM  = 1'b1;

    // segment length in Morse units
    typedef enum logic [1:0] {
        UNITS_1 = 2'd0,
        UNITS_3 = 2'd1,
        UNITS_7 = 2'd2
    } units_t;

    // one letter: element count and pattern, bit i set = element i is a dah
    typedef struct packed {
        logic [ELEM_W-1:0]   len;
        logic [MAX_ELEM-1:0] pat;
    } code_t;

    // one key segment handed from the sequencer to the output stage
    typedef struct packed {
        logic   key_on;
        units_t units;
        logic   last;
    } seg_t;

    // character to Morse code; anything without an entry sends '?'
    function automatic code_t code_lookup(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        code_t             r;
        u = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            u = c - CASE_OFFSET;
        end
        case (u)
            8'd33:  r = '{3'd4, 7'b0000111}; // !
            8'd34:  r = '{3'd6, 7'b0010010}; // "
            8'd36:  r = '{3'd7, 7'b1001000}; // $
            8'd39:  r = '{3'd6, 7'b0011110}; // '
            8'd40:  r = '{3'd5, 7'b0001101}; // (
            8'd41:  r = '{3'd6, 7'b0101101}; // )
            8'd43:  r = '{3'd5, 7'b0001010}; // +
            8'd44:  r = '{3'd6, 7'b0110011}; // ,
            8'd45:  r = '{3'd6, 7'b0100001}; // -
            8'd46:  r = '{3'd6, 7'b0101010}; // .
            8'd47:  r = '{3'd5, 7'b0001001}; // /
            8'd48:  r = '{3'd5, 7'b0011111}; // 0
            8'd49:  r = '{3'd5, 7'b0011110};
            8'd50:  r = '{3'd5, 7'b0011100};
            8'd51:  r = '{3'd5, 7'b0011000};
            8'd52:  r = '{3'd5, 7'b0010000};
            8'd53:  r = '{3'd5, 7'b0000000};
            8'd54:  r = '{3'd5, 7'b0000001};
            8'd55:  r = '{3'd5, 7'b0000011};
            8'd56:  r = '{3'd5, 7'b0000111};
            8'd57:  r = '{3'd5, 7'b0001111}; // 9
            8'd58:  r = '{3'd6, 7'b0000111}; // :
            8'd59:  r = '{3'd6, 7'b0010101}; // ;
            8'd61:  r = '{3'd5, 7'b0010001}; // =
            8'd64:  r = '{3'd6, 7'b0010110}; // @
            8'd65:  r = '{3'd2, 7'b0000010}; // A
            8'd66:  r = '{3'd4, 7'b0000001};
            8'd67:  r = '{3'd4, 7'b0000101};
            8'd68:  r = '{3'd3, 7'b0000001};
            8'd69:  r = '{3'd1, 7'b0000000};
            8'd70:  r = '{3'd4, 7'b0000100};
            8'd71:  r = '{3'd3, 7'b0000011};
            8'd72:  r = '{3'd4, 7'b0000000};
            8'd73:  r = '{3'd2, 7'b0000000};
            8'd74:  r = '{3'd4, 7'b0001110};
            8'd75:  r = '{3'd3, 7'b0000101};
            8'd76:  r = '{3'd4, 7'b0000010};
            8'd77:  r = '{3'd2, 7'b0000011};
            8'd78:  r = '{3'd2, 7'b0000001};
            8'd79:  r = '{3'd3, 7'b0000111};
            8'd80:  r = '{3'd4, 7'b0000110};
            8'd81:  r = '{3'd4, 7'b0001011};
            8'd82:  r = '{3'd3, 7'b0000010};
            8'd83:  r = '{3'd3, 7'b0000000};
            8'd84:  r = '{3'd1, 7'b0000001};
            8'd85:  r = '{3'd3, 7'b0000100};
            8'd86:  r = '{3'd4, 7'b0001000};
            8'd87:  r = '{3'd3, 7'b0000110};
            8'd88:  r = '{3'd4, 7'b0001001};
            8'd89:  r = '{3'd4, 7'b0001101};
            8'd90:  r = '{3'd4, 7'b0000011}; // Z
            8'd91:  r = '{3'd5, 7'b0001101}; // [ same as (
            8'd93:  r = '{3'd6, 7'b0101101}; // ] same as )
            8'd95:  r = '{3'd6, 7'b0101100}; // _
            default: r = '{3'd6, 7'b0001100}; // ?
        endcase
        return r;
    endfunction

endpackage

### src/morse_keyer.sv
// Morse keyer top level: time unit register, segment length unit and
// output register around the segment sequencer. Depends on mk_pkg, mk_seq.
//
//   channel   dir  fields (low bit first)
//   s_        in   tdata: char_code[7:0]; tuser: mode
//   m_        out  tdata: key_on, duration[18:0], 4 zero bits; tlast: last
//   cfg_wr_   in   time_unit[15:0], written when cfg_wr_en is high
//
// A character of n segments (at most 14) is accepted in the idle state, then the
// sequencer hands on one segment per cycle while m_tready stays high, each
// scaled by the single shared add/subtract unit.
// Reset (aresetn low, synchronous) sets time_unit to 50 and starts a word.
// A stall on m_tready holds the output register and the sequencer.

module morse_keyer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // key_on, duration[18:0], pad[3:0]
    output logic        m_tlast,   // last
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import mk_pkg::*;

    logic [UNIT_W-1:0] time_unit_reg;
    logic              seg_valid;
    seg_t              seg;
    logic              seg_take;
    logic [DUR_W-1:0]  opa, opb, dur;
    logic              op_sub;
    logic              m_tvalid_reg;
    logic              key_on_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic              last_reg;

    mk_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .mode      (s_tuser[0]),
        .char_code (s_tdata),
        .seg_valid (seg_valid),
        .seg       (seg),
        .seg_take  (seg_take)
    );

    // time unit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_unit_reg <= TIME_UNIT_RESET;
        end else if (cfg_wr_en) begin
            time_unit_reg <= cfg_wr_data;
        end
    end

    // segment length: 1u = 0+u, 3u = 2u+u, 7u = 8u-u, one shared adder
    always_comb begin
        opb = DUR_W'(time_unit_reg);
        case (seg.units)
            UNITS_3: begin
                opa    = DUR_W'(time_unit_reg) << 1;
                op_sub = 1'b0;
            end
            UNITS_7: begin
                opa    = DUR_W'(time_unit_reg) << 3;
                op_sub = 1'b1;
            end
            default: begin
                opa    = '0;
                op_sub = 1'b0;
            end
        endcase
        dur = op_sub ? (opa - opb) : (opa + opb);
    end

    // output register
    assign seg_take = seg_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (seg_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (seg_take) begin
            key_on_reg <= seg.key_on;
            dur_reg    <= dur;
            last_reg   <= seg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, dur_reg, key_on_reg};
    assign m_tlast  = last_reg;

endmodule

### src/mk_seq.sv
// Segment sequencer: steps through the letter gap, elements and element gaps
// of one character, or the word space, one segment per take. Depends on mk_pkg.

module mk_seq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      mode,
    input  logic [mk_pkg::CHAR_W-1:0] char_code,
    output logic                      seg_valid,
    output mk_pkg::seg_t              seg,
    input  logic                      seg_take
);
    import mk_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic                first_reg, first_next;
    logic                space_reg, space_next;
    logic                gap_reg, gap_next;
    logic [ELEM_W-1:0]   idx_reg, idx_next;
    logic [ELEM_W-1:0]   len_reg, len_next;
    logic [MAX_ELEM-1:0] pat_reg, pat_next;
    code_t               code;
    logic                is_space;

    assign in_ready  = (state_reg == S_IDLE);
    assign seg_valid = (state_reg == S_RUN);
    assign code      = code_lookup(char_code);
    assign is_space  = (mode == MODE_EOM) || (char_code == CHAR_SPACE);

    // current segment
    always_comb begin
        if (space_reg) begin
            seg = '{1'b0, UNITS_7, 1'b1};
        end else if (gap_reg) begin
            seg = '{1'b0, (idx_reg == '0) ? UNITS_3 : UNITS_1, 1'b0};
        end else begin
            seg = '{1'b1, pat_reg[idx_reg] ? UNITS_3 : UNITS_1,
                    (idx_reg == len_reg - 3'd1)};
        end
    end

    // sequencing
    always_comb begin
        state_next = state_reg;
        first_next = first_reg;
        space_next = space_reg;
        gap_next   = gap_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        pat_next   = pat_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_RUN;
                    space_next = is_space;
                    idx_next   = '0;
                    len_next   = code.len;
                    pat_next   = code.pat;
                    gap_next   = !is_space && !first_reg;
                    first_next = is_space;
                end
            end
            S_RUN: begin
                if (seg_take) begin
                    if (seg.last) begin
                        state_next = S_IDLE;
                    end else if (gap_reg) begin
                        gap_next = 1'b0;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                        gap_next = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            first_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
        space_reg <= space_next;
        gap_reg   <= gap_next;
        idx_reg   <= idx_next;
        len_reg   <= len_next;
        pat_reg   <= pat_next;
    end

endmodule

### tb/morse_keyer_tb.sv
// Self-checking testbench for morse_keyer: directed table, then random text in phases
// with different time units. Key segments are predicted locally and checked in order.
// Depends on mk_pkg and morse_keyer.
`timescale 1ns / 100ps

module morse_keyer_tb;
    import mk_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PLAN      = 28;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 56;
    localparam int IDLE_PCT    = 23;

    // one key segment as seen on the result channel
    typedef struct packed {
        bit        key_on;
        bit [18:0] duration;
        bit        last;
    } key_seg_t;

    // directed step: a unit write, or a character / end-of-message transaction
    typedef struct packed {
        bit        is_cfg;
        bit [15:0] unit;
        bit        mode;
        bit [7:0]  ch;
        bit        typed;     // single segment given below instead of predicted
        bit        t_on;
        bit [18:0] t_dur;
    } plan_row_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;   // char_code[7:0]
    logic [0:0]  s_tuser     = '0;   // mode
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;            // key_on, duration[18:0], pad[3:0]
    logic        m_tlast;            // last
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // predictor state
    bit [15:0] unit_ticks = 16'd50;
    bit        word_start = 1'b1;
    key_seg_t  item_segs [$];        // segments of the current character
    key_seg_t  pending_segs [$];     // segments still to come out of the block

    bit no_idle   = 1'b0;
    int n_errors  = 0;
    int cycle_cnt = 0;

    string letter_codes [26] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--.."};
    string digit_codes [10] = '{
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."};

    plan_row_t plan [N_PLAN] = '{
        '{1'b0, 16'd0,     MODE_EOM,  8'h00, 1'b1, 1'b0, 19'd350},    // end of message
        '{1'b0, 16'd0,     MODE_CHAR, 8'h45, 1'b1, 1'b1, 19'd50},     // 'E' opens word
        '{1'b0, 16'd0,     MODE_CHAR, 8'h65, 1'b0, 1'b0, 19'd0},      // 'e'
        '{1'b0, 16'd0,     MODE_CHAR, 8'h20, 1'b1, 1'b0, 19'd350},    // space
        '{1'b0, 16'd0,     MODE_CHAR, 8'h24, 1'b0, 1'b0, 19'd0},      // '$', 7 elements
        '{1'b0, 16'd0,     MODE_CHAR, 8'h24, 1'b0, 1'b0, 19'd0},      // '$' with gap: 14
        '{1'b0, 16'd0,     MODE_CHAR, 8'h00, 1'b0, 1'b0, 19'd0},      // control codes
        '{1'b0, 16'd0,     MODE_CHAR, 8'h1F, 1'b0, 1'b0, 19'd0},
        '{1'b0, 16'd0,     MODE_CHAR, 8'h7F, 1'b0, 1'b0, 19'd0},      // high codes
        '{1'b0, 16'd0,     MODE_CHAR, 8'hFF, 1'b0, 1'b0, 19'd0},
        '{1'b0, 16'd0,     MODE_CHAR, 8'h23, 1'b0, 1'b0, 19'd0},      // '#' has no entry
        '{1'b0, 16'd0,     MODE_CHAR, 8'h21, 1'b0, 1'b0, 19'd0},      // '!'
        '{1'b0, 16'd0,     MODE_CHAR, 8'h5B, 1'b0, 1'b0, 19'd0},      // '['
        '{1'b0, 16'd0,     MODE_CHAR, 8'h61, 1'b0, 1'b0, 19'd0},      // 'a'
        '{1'b0, 16'd0,     MODE_CHAR, 8'h5A, 1'b0, 1'b0, 19'd0},      // 'Z'
        '{1'b0, 16'd0,     MODE_CHAR, 8'h7E, 1'b0, 1'b0, 19'd0},      // '~' has no entry
        '{1'b0, 16'd0,     MODE_EOM,  8'hFF, 1'b1, 1'b0, 19'd350},    // char ignored
        '{1'b1, 16'hFFFF,  MODE_CHAR, 8'h00, 1'b0, 1'b0, 19'd0},
        '{1'b0, 16'd0,     MODE_EOM,  8'h00, 1'b1, 1'b0, 19'd458745},
        '{1'b0, 16'd0,     MODE_CHAR, 8'h54, 1'b1, 1'b1, 19'd196605}, // 'T' opens word
        '{1'b0, 16'd0,     MODE_CHAR, 8'h30, 1'b0, 1'b0, 19'd0},      // '0'
        '{1'b1, 16'd0,     MODE_CHAR, 8'h00, 1'b0, 1'b0, 19'd0},      // zero time unit
        '{1'b0, 16'd0,     MODE_CHAR, 8'h20, 1'b1, 1'b0, 19'd0},
        '{1'b0, 16'd0,     MODE_CHAR, 8'h45, 1'b1, 1'b1, 19'd0},
        '{1'b0, 16'd0,     MODE_CHAR, 8'h51, 1'b0, 1'b0, 19'd0},      // 'Q'
        '{1'b1, 16'd1,     MODE_CHAR, 8'h00, 1'b0, 1'b0, 19'd0},
        '{1'b0, 16'd0,     MODE_EOM,  8'h00, 1'b1, 1'b0, 19'd7},
        '{1'b0, 16'd0,     MODE_CHAR, 8'h40, 1'b0, 1'b0, 19'd0}       // '@'
    };

    morse_keyer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // dot/dash pattern of a byte; anything without a code goes out as '?'
    function automatic string morse_of(input bit [7:0] ch);
        bit [7:0] u;
        u = ch;
        if (u >= 8'd97 && u <= 8'd122) u = u - 8'd32;
        if (u >= 8'd65 && u <= 8'd90) return letter_codes[u - 8'd65];
        if (u >= 8'd48 && u <= 8'd57) return digit_codes[u - 8'd48];
        case (u)
            8'd33: return "---.";
            8'd34: return ".-..-.";
            8'd36: return "...-..-";
            8'd39: return ".----.";
            8'd40: return "-.--.";
            8'd41: return "-.--.-";
            8'd43: return ".-.-.";
            8'd44: return "--..--";
            8'd45: return "-....-";
            8'd46: return ".-.-.-";
            8'd47: return "-..-.";
            8'd58: return "---...";
            8'd59: return "-.-.-.";
            8'd61: return "-...-";
            8'd64: return ".--.-.";
            8'd91: return "-.--.";
            8'd93: return "-.--.-";
            8'd95: return "..--.-";
            default: return "..--..";
        endcase
    endfunction

    function automatic void push_seg(input bit on, input int units);
        key_seg_t s;
        s.key_on   = on;
        s.duration = 19'(units * unit_ticks);
        s.last     = 1'b0;
        item_segs.push_back(s);
    endfunction

    // segments caused by one character or end-of-message; updates the word flag
    function automatic void key_item(input bit m, input bit [7:0] ch);
        string pat;
        item_segs.delete();
        if (m == MODE_EOM || ch == CHAR_SPACE) begin
            push_seg(1'b0, 7);
            word_start = 1'b1;
        end else begin
            pat = morse_of(ch);
            if (word_start) word_start = 1'b0;
            else push_seg(1'b0, 3);
            for (int i = 0; i < pat.len(); i++) begin
                if (i != 0) push_seg(1'b0, 1);
                push_seg(1'b1, (pat[i] == "-") ? 3 : 1);
            end
        end
        item_segs[item_segs.size() - 1].last = 1'b1;
    endfunction

    // present one transaction; returns at the edge where it was taken
    task automatic send_item(input bit m, input bit [7:0] ch, input bit typed = 1'b0,
                             input bit t_on = 1'b0, input bit [18:0] t_dur = '0);
        key_seg_t s;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        key_item(m, ch);
        if (typed) begin
            s = '{t_on, t_dur, 1'b1};
            pending_segs.push_back(s);
        end else begin
            foreach (item_segs[i]) pending_segs.push_back(item_segs[i]);
        end
    endtask

    // hold the input side until the block has emitted everything owed
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge aclk);
    endtask

    task automatic set_unit(input bit [15:0] v);
        drain();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        unit_ticks  = v;
    endtask

    // random character or end-of-message: mostly letters, spaces and punctuation, some noise
    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (r < 8)       send_item(MODE_EOM, 8'($urandom_range(255)));
        else if (r < 20) send_item(MODE_CHAR, CHAR_SPACE);
        else if (r < 35) send_item(MODE_CHAR, 8'($urandom_range(255)));
        else if (r < 75) send_item(MODE_CHAR, 8'($urandom_range(25) +
                                                 ($urandom_range(1) ? 97 : 65)));
        else             send_item(MODE_CHAR, 8'($urandom_range(126, 33)));
    endtask

    // result side: check each segment transaction against the predicted ones, in order
    task automatic take_segment();
        key_seg_t want;
        if (pending_segs.size() == 0) begin
            $error("unexpected segment: key_on %0d duration %0d last %0d",
                   m_tdata[0], m_tdata[19:1], m_tlast);
            n_errors++;
        end else begin
            want = pending_segs.pop_front();
            if (m_tdata[0] !== want.key_on) begin
                $error("key_on: expected %0d, got %0d", want.key_on, m_tdata[0]);
                n_errors++;
            end
            if (m_tdata[19:1] !== want.duration) begin
                $error("duration: expected %0d, got %0d", want.duration, m_tdata[19:1]);
                n_errors++;
            end
            if (m_tlast !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, m_tlast);
                n_errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) take_segment();
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // main sequence
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < N_PLAN; i++) begin
            if (plan[i].is_cfg) set_unit(plan[i].unit);
            else send_item(plan[i].mode, plan[i].ch, plan[i].typed,
                           plan[i].t_on, plan[i].t_dur);
        end

        // random phases, each with its own time unit
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: set_unit(16'($urandom_range(65535, 1)));
                1: set_unit(16'd3);
                2: set_unit(16'hFFFF);
                3: set_unit(16'($urandom_range(300, 1)));
                4: set_unit(16'd1);
                default: set_unit(16'($urandom_range(65535)));
            endcase
            no_idle = (p == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // one mid-phase pause until the output side has caught up
                if (p == 3 && k == PHASE_ITEMS / 2) drain();
                send_random();
            end
            no_idle = 1'b0;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (n_errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
src/mk_pkg.sv
src/mk_seq.sv
src/morse_keyer.sv
tb/morse_keyer_tb.sv
